// File: hdl/assert_macros.svh
// Assertion macros for the event scheduler back end.
// Depends on nothing; expects signals named clock and reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define PES_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pwm event scheduler: same-cycle check failed");

// Consequence must hold in the cycle after the antecedent.
`define PES_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pwm event scheduler: next-cycle check failed");

`endif

// File: hdl/pes_pkg.sv
// Shared constants and types for the PWM event scheduler.
// Depends on nothing; used by every module of the block.
package pes_pkg;

   // Default counter width and fixed field widths.
   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int VALUE_BITS         = 16;
   localparam int ID_BITS            = 4;

   // Nine events per period: three ADC samples, three low-side, three high-side edges.
   localparam int EVENT_COUNT = 9;
   localparam int PHASE_COUNT = 3;
   localparam int ADC_BASE    = 0;
   localparam int LOW_BASE    = 3;
   localparam int HIGH_BASE   = 6;
   localparam int STEP_BITS   = $clog2(EVENT_COUNT);

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Register file.
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PERIOD    = 3'd0,
      REG_MIN_WIDTH = 3'd1,
      REG_DEADTIME  = 3'd2,
      REG_ADC_OFF   = 3'd3,
      REG_ADC_CONV  = 3'd4
   } csr_index_type;

   localparam int PERIOD_RESET    = 2940;
   localparam int MIN_WIDTH_RESET = 4;
   localparam int DEADTIME_RESET  = 15;
   localparam int ADC_OFF_RESET   = 33;
   localparam int ADC_CONV_RESET  = 108;

endpackage

// File: hdl/pwm_event_scheduler.sv
// A duty transaction passes the two front stages and the queue, is loaded into the
// sorter and takes nine sort passes before its first result; the nine results follow on
// consecutive cycles when pop is held. The single sorter loads a transaction, runs nine
// odd-even passes and emits its nine results before it loads the next one.
// Reset is synchronous and active high: registers take their defaults, the kept
// event order becomes 0 through 8, and the queue and the result register empty.
module pwm_event_scheduler #(
   parameter int COUNT_BITS = pes_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [pes_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COUNT_BITS-1:0]              csr_write_data,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [COUNT_BITS-1:0]              req_duty_a,
   input  logic [COUNT_BITS-1:0]              req_duty_b,
   input  logic [COUNT_BITS-1:0]              req_duty_c,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [pes_pkg::ID_BITS-1:0]        rsp_event_id,
   output logic [pes_pkg::VALUE_BITS-1:0]     rsp_compare_value,
   output logic                               rsp_last_event
);
   import pes_pkg::*;

   localparam int WORD_BITS = EVENT_COUNT * COUNT_BITS;

   logic                 q_push;
   logic                 q_full;
   logic [WORD_BITS-1:0] q_push_data;
   logic                 q_pop;
   logic                 q_empty;
   logic [WORD_BITS-1:0] q_pop_data;

   // Front end: registers and compare value computation.
   pes_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_duty_a     (req_duty_a),
      .req_duty_b     (req_duty_b),
      .req_duty_c     (req_duty_c),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (q_push_data)
   );

   // Queue between the two halves.
   pes_queue #(
      .WIDTH(WORD_BITS),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   // Back end: sorter and result register.
   pes_back #(
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_data            (q_pop_data),
      .q_pop             (q_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_event_id      (rsp_event_id),
      .rsp_compare_value (rsp_compare_value),
      .rsp_last_event    (rsp_last_event)
   );

endmodule

// File: hdl/pes_front.sv
// Front end: holds the configuration registers, accepts duty transactions and
// computes the nine compare values in two register stages. Depends on pes_pkg.
module pes_front #(
   parameter int COUNT_BITS = pes_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          csr_write_en,
   input  logic [pes_pkg::CSR_INDEX_BITS-1:0]            csr_index,
   input  logic [COUNT_BITS-1:0]                         csr_write_data,
   input  logic                                          req_push,
   output logic                                          req_full,
   input  logic [COUNT_BITS-1:0]                         req_duty_a,
   input  logic [COUNT_BITS-1:0]                         req_duty_b,
   input  logic [COUNT_BITS-1:0]                         req_duty_c,
   input  logic                                          q_full,
   output logic                                          q_push,
   output logic [pes_pkg::EVENT_COUNT*COUNT_BITS-1:0]    q_data
);
   import pes_pkg::*;

   // Signed working width: two extra bits of headroom and a sign bit.
   localparam int W = COUNT_BITS + 3;
   typedef logic signed [W-1:0] wide_type;

   function automatic wide_type widen(input logic [COUNT_BITS-1:0] x);
      return wide_type'(x);
   endfunction

   // Configuration registers.
   logic [COUNT_BITS-1:0] period_ff, period_in;
   logic [COUNT_BITS-1:0] min_width_ff, min_width_in;
   logic [COUNT_BITS-1:0] deadtime_ff, deadtime_in;
   logic [COUNT_BITS-1:0] adc_off_ff, adc_off_in;
   logic [COUNT_BITS-1:0] adc_conv_ff, adc_conv_in;

   // Stage A: captured duties.
   logic                  a_valid_ff, a_valid_in;
   logic [COUNT_BITS-1:0] duty_ff [PHASE_COUNT];
   logic [COUNT_BITS-1:0] duty_in [PHASE_COUNT];

   // Stage B: raw sums before clamping and snapping.
   logic     b_valid_ff, b_valid_in;
   wide_type adc_raw_ff  [PHASE_COUNT];
   wide_type adc_raw_in  [PHASE_COUNT];
   wide_type low_raw_ff  [PHASE_COUNT];
   wide_type low_raw_in  [PHASE_COUNT];
   wide_type high_raw_ff [PHASE_COUNT];
   wide_type high_raw_in [PHASE_COUNT];
   wide_type limit_ff, limit_in;
   wide_type per_ff, per_in;
   wide_type minw_ff, minw_in;

   logic     req_accept;
   logic     a_move;
   logic     b_move;
   wide_type p_w, mw_w, dt_w, off_w, conv_w, duty_w;

   // Pipeline handshake: stage B drains into the queue, stage A into stage B.
   assign b_move     = b_valid_ff && !q_full;
   assign a_move     = a_valid_ff && (!b_valid_ff || b_move);
   assign req_full   = a_valid_ff && !a_move;
   assign req_accept = req_push && !req_full;
   assign q_push     = b_move;

   // Register writes; an index beyond the register list is ignored.
   always_comb begin
      period_in    = period_ff;
      min_width_in = min_width_ff;
      deadtime_in  = deadtime_ff;
      adc_off_in   = adc_off_ff;
      adc_conv_in  = adc_conv_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            REG_PERIOD:    period_in    = csr_write_data;
            REG_MIN_WIDTH: min_width_in = csr_write_data;
            REG_DEADTIME:  deadtime_in  = csr_write_data;
            REG_ADC_OFF:   adc_off_in   = csr_write_data;
            REG_ADC_CONV:  adc_conv_in  = csr_write_data;
            default: ;
         endcase
      end
   end

   // Stage A capture.
   always_comb begin
      a_valid_in = (a_valid_ff && !a_move) || req_accept;
      duty_in    = duty_ff;
      if (req_accept) begin
         duty_in[0] = req_duty_a;
         duty_in[1] = req_duty_b;
         duty_in[2] = req_duty_c;
      end
   end

   // Stage A to B: form the ADC sums, the low-side sums, the high-side edges and the snap limit.
   always_comb begin
      p_w    = widen(period_ff);
      mw_w   = widen(min_width_ff);
      dt_w   = widen(deadtime_ff);
      off_w  = widen(adc_off_ff);
      conv_w = widen(adc_conv_ff);
      duty_w = '0;

      b_valid_in  = (b_valid_ff && !b_move) || a_move;
      adc_raw_in  = adc_raw_ff;
      low_raw_in  = low_raw_ff;
      high_raw_in = high_raw_ff;
      limit_in    = limit_ff;
      per_in      = per_ff;
      minw_in     = minw_ff;
      if (a_move) begin
         adc_raw_in[0] = p_w - off_w;
         adc_raw_in[1] = p_w + off_w - conv_w;
         adc_raw_in[2] = p_w + off_w - conv_w - conv_w;
         for (int k = 0; k < PHASE_COUNT; k++) begin
            duty_w         = widen(duty_ff[k]);
            low_raw_in[k]  = (duty_w < mw_w) ? wide_type'(0) : duty_w + dt_w;
            high_raw_in[k] = duty_w;
         end
         limit_in = p_w - mw_w;
         per_in   = p_w;
         minw_in  = mw_w;
      end
   end

   // Stage B output: clamp the ADC points and snap the edges, then pack.
   always_comb begin
      q_data = '0;
      for (int k = 0; k < PHASE_COUNT; k++) begin
         // ADC samples saturate to the range zero to period.
         if (adc_raw_ff[k] < 0) begin
            q_data[(ADC_BASE + k)*COUNT_BITS +: COUNT_BITS] = '0;
         end else if (adc_raw_ff[k] > per_ff) begin
            q_data[(ADC_BASE + k)*COUNT_BITS +: COUNT_BITS] = COUNT_BITS'(per_ff);
         end else begin
            q_data[(ADC_BASE + k)*COUNT_BITS +: COUNT_BITS] = COUNT_BITS'(adc_raw_ff[k]);
         end

         // Low-side edges snap to zero or to the period near the ends.
         if (low_raw_ff[k] < minw_ff) begin
            q_data[(LOW_BASE + k)*COUNT_BITS +: COUNT_BITS] = '0;
         end else if (low_raw_ff[k] > limit_ff) begin
            q_data[(LOW_BASE + k)*COUNT_BITS +: COUNT_BITS] = COUNT_BITS'(per_ff);
         end else begin
            q_data[(LOW_BASE + k)*COUNT_BITS +: COUNT_BITS] = COUNT_BITS'(low_raw_ff[k]);
         end

         // High-side edges snap the same way.
         if (high_raw_ff[k] < minw_ff) begin
            q_data[(HIGH_BASE + k)*COUNT_BITS +: COUNT_BITS] = '0;
         end else if (high_raw_ff[k] > limit_ff) begin
            q_data[(HIGH_BASE + k)*COUNT_BITS +: COUNT_BITS] = COUNT_BITS'(per_ff);
         end else begin
            q_data[(HIGH_BASE + k)*COUNT_BITS +: COUNT_BITS] = COUNT_BITS'(high_raw_ff[k]);
         end
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= COUNT_BITS'(PERIOD_RESET);
         min_width_ff <= COUNT_BITS'(MIN_WIDTH_RESET);
         deadtime_ff  <= COUNT_BITS'(DEADTIME_RESET);
         adc_off_ff   <= COUNT_BITS'(ADC_OFF_RESET);
         adc_conv_ff  <= COUNT_BITS'(ADC_CONV_RESET);
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
      end else begin
         period_ff    <= period_in;
         min_width_ff <= min_width_in;
         deadtime_ff  <= deadtime_in;
         adc_off_ff   <= adc_off_in;
         adc_conv_ff  <= adc_conv_in;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
      end
      duty_ff     <= duty_in;
      adc_raw_ff  <= adc_raw_in;
      low_raw_ff  <= low_raw_in;
      high_raw_ff <= high_raw_in;
      limit_ff    <= limit_in;
      per_ff      <= per_in;
      minw_ff     <= minw_in;
   end

endmodule

// File: hdl/pes_queue.sv
// Short first-in first-out queue that decouples the front end from the sorter.
// Depends on pes_pkg for its default width and depth.
module pes_queue #(
   parameter int WIDTH = pes_pkg::EVENT_COUNT * pes_pkg::COUNT_BITS_DEFAULT,
   parameter int DEPTH = pes_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   import pes_pkg::*;

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W    = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == COUNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/pes_back.sv
// Back end: stable descending sort of the nine events from the kept order, then one
// result per cycle while the slot is free. Depends on pes_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pes_back #(
   parameter int COUNT_BITS = pes_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       q_empty,
   input  logic [pes_pkg::EVENT_COUNT*COUNT_BITS-1:0] q_data,
   output logic                                       q_pop,
   input  logic                                       rsp_pop,
   output logic                                       rsp_empty,
   output logic [pes_pkg::ID_BITS-1:0]                rsp_event_id,
   output logic [pes_pkg::VALUE_BITS-1:0]             rsp_compare_value,
   output logic                                       rsp_last_event
);
   import pes_pkg::*;

   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(EVENT_COUNT - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SORT,
      ST_EMIT
   } state_type;

   function automatic logic [COUNT_BITS-1:0] pick(
      input logic [EVENT_COUNT*COUNT_BITS-1:0] word,
      input logic [ID_BITS-1:0]                id
   );
      logic [COUNT_BITS-1:0] res;
      res = '0;
      for (int j = 0; j < EVENT_COUNT; j++) begin
         if (id == ID_BITS'(j)) begin
            res = word[j*COUNT_BITS +: COUNT_BITS];
         end
      end
      return res;
   endfunction

   state_type             state_ff, state_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   // Lane ids hold the kept event order; lane values travel with them.
   logic [ID_BITS-1:0]    id_ff  [EVENT_COUNT];
   logic [ID_BITS-1:0]    id_in  [EVENT_COUNT];
   logic [COUNT_BITS-1:0] val_ff [EVENT_COUNT];
   logic [COUNT_BITS-1:0] val_in [EVENT_COUNT];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ID_BITS-1:0]    rsp_id_ff, rsp_id_in;
   logic [VALUE_BITS-1:0] rsp_val_ff, rsp_val_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  slot_free;
   logic                  rsp_load;
   logic [EVENT_COUNT-1:0] id_mask;
   logic                  lanes_sorted;

   assign rsp_empty         = !rsp_valid_ff;
   assign rsp_event_id      = rsp_id_ff;
   assign rsp_compare_value = rsp_val_ff;
   assign rsp_last_event    = rsp_last_ff;

   assign slot_free = !rsp_valid_ff || rsp_pop;
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign rsp_load  = (state_ff == ST_EMIT) && slot_free;

   // Sequencer: load from the queue, odd-even transposition passes, then emit.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      id_in        = id_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_id_in    = rsp_id_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               for (int i = 0; i < EVENT_COUNT; i++) begin
                  val_in[i] = pick(q_data, id_ff[i]);
               end
               step_in  = '0;
               state_in = ST_SORT;
            end
         end
         ST_SORT: begin
            // Disjoint neighbour pairs; a swap only on a strict less keeps ties stable.
            for (int i = 0; i < EVENT_COUNT - 1; i++) begin
               if ((i % 2) == int'(step_ff[0]) && (val_ff[i] < val_ff[i+1])) begin
                  id_in[i]    = id_ff[i+1];
                  id_in[i+1]  = id_ff[i];
                  val_in[i]   = val_ff[i+1];
                  val_in[i+1] = val_ff[i];
               end
            end
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            // Emit lane 0 and rotate, so nine rotations restore the kept order.
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = id_ff[0];
               rsp_val_in   = VALUE_BITS'(val_ff[0]);
               rsp_last_in  = (step_ff == LAST_STEP);
               for (int i = 0; i < EVENT_COUNT - 1; i++) begin
                  id_in[i]  = id_ff[i+1];
                  val_in[i] = val_ff[i+1];
               end
               id_in[EVENT_COUNT-1]  = id_ff[0];
               val_in[EVENT_COUNT-1] = val_ff[0];
               if (step_ff == LAST_STEP) begin
                  step_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, kept order and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < EVENT_COUNT; i++) begin
            id_ff[i] <= ID_BITS'(i);
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         id_ff        <= id_in;
      end
      val_ff      <= val_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Checks on the kept order and the sort result.
   always_comb begin
      id_mask      = '0;
      lanes_sorted = 1'b1;
      for (int i = 0; i < EVENT_COUNT; i++) begin
         id_mask[id_ff[i]] = 1'b1;
      end
      for (int i = 0; i < EVENT_COUNT - 1; i++) begin
         if (val_ff[i] < val_ff[i+1]) begin
            lanes_sorted = 1'b0;
         end
      end
   end

   `PES_ASSERT_SAME(a_order_is_permutation, 1'b1, id_mask == '1)
   `PES_ASSERT_SAME(a_sorted_before_emit, (state_ff == ST_EMIT) && (step_ff == '0), lanes_sorted)
   `PES_ASSERT_NEXT(a_last_returns_idle, rsp_load && (step_ff == LAST_STEP), state_ff == ST_IDLE)
   `PES_ASSERT_NEXT(a_pop_starts_sort, q_pop, (state_ff == ST_SORT) && (step_ff == '0))

endmodule

// File: tb/pwm_event_scheduler_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for pwm_event_scheduler: drives duty transactions and settings,
// predicts the ordered compare events of each period and checks every result transaction.
// Depends on pes_pkg and the pwm_event_scheduler RTL.
module pwm_event_scheduler_test;
   import pes_pkg::*;

   localparam int CB            = COUNT_BITS_DEFAULT;
   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 32;
   localparam int STALL_LIMIT   = 4000;
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASE_ITEMS   = 32;

   typedef struct packed {
      logic [CB-1:0] a;
      logic [CB-1:0] b;
      logic [CB-1:0] c;
   } duty_set_type;

   typedef struct packed {
      logic [ID_BITS-1:0]    id;
      logic [VALUE_BITS-1:0] value;
      logic                  last;
   } sched_event_type;

   logic                      clock;
   logic                      reset          = 1'b1;
   logic                      csr_write_en   = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index      = '0;
   logic [CB-1:0]             csr_write_data = '0;
   logic                      req_push       = 1'b0;
   logic                      req_full;
   logic [CB-1:0]             req_duty_a     = '0;
   logic [CB-1:0]             req_duty_b     = '0;
   logic [CB-1:0]             req_duty_c     = '0;
   logic                      rsp_empty;
   logic                      rsp_pop        = 1'b0;
   logic [ID_BITS-1:0]        rsp_event_id;
   logic [VALUE_BITS-1:0]     rsp_compare_value;
   logic                      rsp_last_event;

   // Predictor state: register copies and the event order kept between periods.
   logic [CB-1:0]      cfg_period     = CB'(PERIOD_RESET);
   logic [CB-1:0]      cfg_min_width  = CB'(MIN_WIDTH_RESET);
   logic [CB-1:0]      cfg_deadtime   = CB'(DEADTIME_RESET);
   logic [CB-1:0]      cfg_adc_offset = CB'(ADC_OFF_RESET);
   logic [CB-1:0]      cfg_adc_conv   = CB'(ADC_CONV_RESET);
   logic [ID_BITS-1:0] kept_order [EVENT_COUNT];

   duty_set_type    pending_duties [$];
   sched_event_type expected_events [$];
   int              mismatch_count = 0;
   int              stall_cycles   = 0;
   int              send_idle_pct  = 0;
   int              recv_idle_pct  = 0;

   pwm_event_scheduler u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_duty_a        (req_duty_a),
      .req_duty_b        (req_duty_b),
      .req_duty_c        (req_duty_c),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_event_id      (rsp_event_id),
      .rsp_compare_value (rsp_compare_value),
      .rsp_last_event    (rsp_last_event)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Saturate an ADC sample point to the counter range.
   function automatic longint clamp_to_period(input longint v, input longint p);
      if (v < 0) return 0;
      if (v > p) return p;
      return v;
   endfunction

   // Edges within the minimal width of either end snap to that end.
   function automatic longint snap_edge(input longint x, input longint p, input longint mw);
      if (x < mw) return 0;
      if (x > p - mw) return p;
      return x;
   endfunction

   // Compute the nine compare values of a period, stable-sort the kept order
   // descending by value, and queue the nine events in the new order.
   function automatic void predict_event_order(input duty_set_type duties);
      longint          p, mw, dt, off, conv, duty, low;
      longint          comp [EVENT_COUNT];
      logic [CB-1:0]   phase_duty [PHASE_COUNT];
      logic [ID_BITS-1:0] a, b;
      bit              swapped;
      sched_event_type ev;
      p    = cfg_period;
      mw   = cfg_min_width;
      dt   = cfg_deadtime;
      off  = cfg_adc_offset;
      conv = cfg_adc_conv;
      phase_duty[0] = duties.a;
      phase_duty[1] = duties.b;
      phase_duty[2] = duties.c;
      comp[ADC_BASE]     = clamp_to_period(p - off, p);
      comp[ADC_BASE + 1] = clamp_to_period(p + off - conv, p);
      comp[ADC_BASE + 2] = clamp_to_period(p + off - 2 * conv, p);
      for (int k = 0; k < PHASE_COUNT; k++) begin
         duty = phase_duty[k];
         low  = (duty < mw) ? 0 : duty + dt;
         comp[LOW_BASE + k]  = snap_edge(low, p, mw);
         comp[HIGH_BASE + k] = snap_edge(duty, p, mw);
      end
      // Bubble passes until nothing moves; only strictly smaller values move down.
      do begin
         swapped = 1'b0;
         for (int k = 1; k < EVENT_COUNT; k++) begin
            a = kept_order[k - 1];
            b = kept_order[k];
            if (comp[a] < comp[b]) begin
               kept_order[k - 1] = b;
               kept_order[k]     = a;
               swapped           = 1'b1;
            end
         end
      end while (swapped);
      for (int k = 0; k < EVENT_COUNT; k++) begin
         ev.id    = kept_order[k];
         ev.value = VALUE_BITS'(comp[kept_order[k]]);
         ev.last  = (k == EVENT_COUNT - 1);
         expected_events.push_back(ev);
      end
   endfunction

   // Driver: presents pending duty sets, holding each until the block takes it.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predict_event_order('{req_duty_a, req_duty_b, req_duty_c});
            void'(pending_duties.pop_front());
         end
         if (!req_push || !req_full) begin
            if (pending_duties.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_push   <= 1'b1;
               req_duty_a <= pending_duties[0].a;
               req_duty_b <= pending_duties[0].b;
               req_duty_c <= pending_duties[0].c;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Monitor: pops results at random and checks each against the oldest expectation.
   always @(posedge clock) begin
      sched_event_type want;
      bit              unexpected;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            unexpected = (expected_events.size() == 0);
            want       = unexpected ? '0 : expected_events.pop_front();
            if (unexpected || rsp_event_id !== want.id || rsp_compare_value !== want.value
                || rsp_last_event !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  if (unexpected) begin
                     $display("%0t: unexpected result id %0d value %0d last %0b", $realtime,
                              rsp_event_id, rsp_compare_value, rsp_last_event);
                  end else begin
                     $display("%0t: mismatch expected id %0d value %0d last %0b,",
                              $realtime, want.id, want.value, want.last,
                              " got id %0d value %0d last %0b",
                              rsp_event_id, rsp_compare_value, rsp_last_event);
                  end
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: ends the run when no transaction moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic add_duty_set(input logic [CB-1:0] a, input logic [CB-1:0] b,
                               input logic [CB-1:0] c);
      pending_duties.push_back('{a, b, c});
   endtask

   // Wait until every duty set is taken and every result has come, then let the block settle.
   task automatic drain_block();
      while (pending_duties.size() > 0 || expected_events.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; the predictor copy follows the index decode of the block.
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CB-1:0] value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (index)
         REG_PERIOD:    cfg_period     = value;
         REG_MIN_WIDTH: cfg_min_width  = value;
         REG_DEADTIME:  cfg_deadtime   = value;
         REG_ADC_OFF:   cfg_adc_offset = value;
         REG_ADC_CONV:  cfg_adc_conv   = value;
         default: ;
      endcase
   endtask

   task automatic write_settings(input logic [CB-1:0] p, input logic [CB-1:0] m,
                                 input logic [CB-1:0] d, input logic [CB-1:0] o,
                                 input logic [CB-1:0] c);
      write_register(REG_PERIOD, p);
      write_register(REG_MIN_WIDTH, m);
      write_register(REG_DEADTIME, d);
      write_register(REG_ADC_OFF, o);
      write_register(REG_ADC_CONV, c);
   endtask

   function automatic logic [CB-1:0] pick_extreme();
      case ($urandom_range(2))
         0:       return '0;
         1:       return CB'(1);
         default: return '1;
      endcase
   endfunction

   // Realistic settings half the time, otherwise the full range or the extremes.
   task automatic apply_random_settings();
      case ($urandom_range(3))
         0: write_settings(CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
                           CB'($urandom));
         1: write_settings(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                           pick_extreme());
         default: write_settings(CB'($urandom_range(4000, 50)), CB'($urandom_range(20, 0)),
                                 CB'($urandom_range(60, 0)), CB'($urandom_range(100, 0)),
                                 CB'($urandom_range(300, 0)));
      endcase
   endtask

   // Random duties, many aimed at the snapping boundaries and at ties with other events.
   function automatic logic [CB-1:0] random_duty();
      int p, m;
      p = cfg_period;
      m = cfg_min_width;
      case ($urandom_range(6))
         0:       return CB'($urandom);
         1:       return CB'($urandom_range(p, 0));
         2:       return CB'(m + $urandom_range(4) - 2);
         3:       return CB'(p - m + $urandom_range(4) - 2);
         4:       return CB'(p - cfg_adc_offset - cfg_deadtime * $urandom_range(1));
         5:       return CB'(p / 2);
         default: return CB'($urandom_range(p, 0) & 16'hFFF0);
      endcase
   endfunction

   task automatic add_random_duty_set();
      logic [CB-1:0] a, b, c;
      a = random_duty();
      b = ($urandom_range(99) < 15) ? a : random_duty();
      c = ($urandom_range(99) < 10) ? b : random_duty();
      add_duty_set(a, b, c);
   endtask

   // Stimulus sequence: directed cases under several settings, then random phases.
   initial begin
      for (int k = 0; k < EVENT_COUNT; k++) kept_order[k] = ID_BITS'(k);
      send_idle_pct = 35;
      recv_idle_pct = 66;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: zero and full-scale duties, both snapping boundaries,
      // ties with the ADC points and repeated equal duties.
      add_duty_set(0, 0, 0);
      add_duty_set('1, '1, '1);
      add_duty_set(3, 4, 5);
      add_duty_set(2936, 2937, 2940);
      add_duty_set(2907, 2850, 2742);
      add_duty_set(1470, 1470, 1470);
      add_duty_set(1470, 1470, 1470);
      add_duty_set(100, 2000, 1000);
      add_duty_set(2000, 1000, 100);
      add_duty_set(2921, 2922, 0);
      add_duty_set(16'h5555, 16'hAAAA, 16'h00FF);
      drain_block();

      // Writes to indexes beyond the register file must leave the settings alone.
      for (int idx = int'(REG_ADC_CONV) + 1; idx < (1 << CSR_INDEX_BITS); idx++) begin
         write_register(CSR_INDEX_BITS'(idx), '1);
      end
      add_duty_set(500, 1500, 2500);
      add_duty_set(2930, 10, 1);
      drain_block();

      // A period of zero collapses every compare value.
      write_settings(0, CB'(MIN_WIDTH_RESET), CB'(DEADTIME_RESET), CB'(ADC_OFF_RESET),
                     CB'(ADC_CONV_RESET));
      add_duty_set(0, 0, 0);
      add_duty_set(1000, 3, '1);
      drain_block();

      // Minimal width above half the period.
      write_settings(100, 80, 10, 5, 20);
      add_duty_set(79, 80, 50);
      add_duty_set(20, 0, 100);
      drain_block();

      // Full-scale period, deadtime and ADC timing with no minimal width.
      write_settings('1, 0, '1, '1, '1);
      add_duty_set('1, 0, 32768);
      add_duty_set(1, 65534, 0);
      drain_block();

      // Smallest nonzero period with everything else zero.
      write_settings(1, 0, 0, 0, 0);
      add_duty_set(0, 1, 2);
      add_duty_set(1, 1, 0);
      drain_block();

      // Random phases under the three idling regimes.
      for (int regime = 0; regime < 3; regime++) begin
         case (regime)
            0: begin
               send_idle_pct = 35;
               recv_idle_pct = 66;
            end
            1: begin
               send_idle_pct = 66;
               recv_idle_pct = 35;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         repeat (2) begin
            apply_random_settings();
            repeat (PHASE_ITEMS) add_random_duty_set();
            drain_block();
         end
      end

      if (mismatch_count == 0 && expected_events.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
